// ----- rtl/core/ssalu_pkg.sv -----
package ssalu_pkg;

   localparam int NUM_SEG_CODES = 8;
   localparam int NUM_MAIN_SEGS = 5;
   localparam int QUEUE_WORDS   = 2;
   localparam int OUT_BITS      = 16;

   localparam logic [3:0] OP_PUSH = 4'd0;
   localparam logic [3:0] OP_POP  = 4'd1;
   localparam logic [3:0] OP_PEEK = 4'd2;
   localparam logic [3:0] OP_ADD  = 4'd3;
   localparam logic [3:0] OP_SUB  = 4'd4;
   localparam logic [3:0] OP_NEG  = 4'd5;
   localparam logic [3:0] OP_EQ   = 4'd6;
   localparam logic [3:0] OP_GT   = 4'd7;
   localparam logic [3:0] OP_LT   = 4'd8;
   localparam logic [3:0] OP_AND  = 4'd9;
   localparam logic [3:0] OP_OR   = 4'd10;
   localparam logic [3:0] OP_NOT  = 4'd11;

   localparam logic [2:0] SEG_LOCAL    = 3'd0;
   localparam logic [2:0] SEG_ARGUMENT = 3'd1;
   localparam logic [2:0] SEG_THIS     = 3'd2;
   localparam logic [2:0] SEG_THAT     = 3'd3;
   localparam logic [2:0] SEG_STATIC   = 3'd4;
   localparam logic [2:0] SEG_TEMP     = 3'd5;
   localparam logic [2:0] SEG_POINTER  = 3'd6;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_FEW      = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef enum logic [2:0] {
      K_PUSH,
      K_POP,
      K_PEEK,
      K_ALU,
      K_NOP
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [3:0]         op;
      logic               unary;
      logic [2:0]         segment;
      logic signed [15:0] value;
   } cmd_type;

endpackage

// ----- rtl/core/ssalu_ram.sv -----
module ssalu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/ssalu_front.sv -----
module ssalu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [3:0]         operation,
   input  logic [2:0]         segment,
   input  logic signed [15:0] value,
   output logic               cmd_valid,
   output ssalu_pkg::cmd_type cmd,
   input  logic               cmd_take
);

   import ssalu_pkg::*;

   cmd_type    q_ff [QUEUE_WORDS];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       accept;
   cmd_type    decoded;

   always_comb begin
      decoded.op      = operation;
      decoded.segment = segment;
      decoded.value   = value;
      decoded.unary   = (operation == OP_NEG) || (operation == OP_NOT);
      unique case (operation)
         OP_PUSH: decoded.kind = K_PUSH;
         OP_POP:  decoded.kind = K_POP;
         OP_PEEK: decoded.kind = K_PEEK;
         OP_ADD, OP_SUB, OP_NEG, OP_EQ, OP_GT, OP_LT, OP_AND, OP_OR, OP_NOT: begin
            decoded.kind = K_ALU;
         end
         default: decoded.kind = K_NOP;
      endcase
   end

   assign full      = (count_ff == 2'(QUEUE_WORDS));
   assign accept    = push && !full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(accept) - 2'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= decoded;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/core/ssalu_back.sv -----
module ssalu_back #(
   parameter int DEPTH         = 256,
   parameter int TEMP_DEPTH    = 8,
   parameter int POINTER_DEPTH = 2,
   parameter int WORD_BITS     = 16,
   parameter int RAM_WORDS     = 5 * 256 + 8 + 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  ssalu_pkg::cmd_type           cmd,
   output logic                         cmd_take,
   output logic [$clog2(RAM_WORDS)-1:0] ram_addr,
   output logic                         ram_we,
   output logic [WORD_BITS-1:0]         ram_wdata,
   input  logic [WORD_BITS-1:0]         ram_rdata,
   output logic                         empty,
   input  logic                         pop,
   output logic signed [15:0]           data,
   output logic [1:0]                   status
);

   import ssalu_pkg::*;

   localparam int ADDR_BITS = $clog2(RAM_WORDS);
   localparam int MAX_CAP0  = (DEPTH > TEMP_DEPTH) ? DEPTH : TEMP_DEPTH;
   localparam int MAX_CAP   = (MAX_CAP0 > POINTER_DEPTH) ? MAX_CAP0 : POINTER_DEPTH;
   localparam int TOP_BITS  = $clog2(MAX_CAP + 1);
   localparam int EXT_BITS  = (WORD_BITS > OUT_BITS) ? WORD_BITS : OUT_BITS;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ_A,
      S_CALC
   } state_type;

   function automatic logic [ADDR_BITS-1:0] seg_base(input logic [2:0] s);
      logic [ADDR_BITS-1:0] b;
      case (s)
         SEG_LOCAL:    b = '0;
         SEG_ARGUMENT: b = ADDR_BITS'(DEPTH);
         SEG_THIS:     b = ADDR_BITS'(2 * DEPTH);
         SEG_THAT:     b = ADDR_BITS'(3 * DEPTH);
         SEG_STATIC:   b = ADDR_BITS'(4 * DEPTH);
         SEG_TEMP:     b = ADDR_BITS'(NUM_MAIN_SEGS * DEPTH);
         SEG_POINTER:  b = ADDR_BITS'(NUM_MAIN_SEGS * DEPTH + TEMP_DEPTH);
         default:      b = '0;
      endcase
      return b;
   endfunction

   function automatic logic [TOP_BITS-1:0] seg_cap(input logic [2:0] s);
      logic [TOP_BITS-1:0] c;
      case (s)
         SEG_LOCAL, SEG_ARGUMENT, SEG_THIS, SEG_THAT, SEG_STATIC: c = TOP_BITS'(DEPTH);
         SEG_TEMP:    c = TOP_BITS'(TEMP_DEPTH);
         SEG_POINTER: c = TOP_BITS'(POINTER_DEPTH);
         default:     c = '0;
      endcase
      return c;
   endfunction

   state_type             state_ff;
   state_type             state_in;
   logic [TOP_BITS-1:0]   tops_ff [NUM_SEG_CODES];
   logic [TOP_BITS-1:0]   tops_in [NUM_SEG_CODES];
   cmd_type               cmd_ff;
   cmd_type               cmd_in;
   logic [WORD_BITS-1:0]  b_ff;
   logic [WORD_BITS-1:0]  b_in;
   logic                  pend_ff;
   logic                  pend_in;
   logic signed [15:0]    pend_data_ff;
   logic signed [15:0]    pend_data_in;
   logic [1:0]            pend_status_ff;
   logic [1:0]            pend_status_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic signed [15:0]    out_data_ff;
   logic signed [15:0]    out_data_in;
   logic [1:0]            out_status_ff;
   logic [1:0]            out_status_in;

   logic                  move;
   logic                  pend_free;
   logic [TOP_BITS-1:0]   top_h;
   logic [TOP_BITS-1:0]   top0;
   logic [ADDR_BITS-1:0]  base_h;
   logic [EXT_BITS-1:0]   value_ext;
   logic [WORD_BITS-1:0]  alu_a;
   logic [WORD_BITS-1:0]  alu_b;
   logic [WORD_BITS-1:0]  alu_r;
   logic [EXT_BITS-1:0]   r_ext;
   logic [EXT_BITS-1:0]   rd_ext;

   assign move      = pend_ff && (!out_valid_ff || pop);
   assign pend_free = !pend_ff || move;
   assign cmd_take  = (state_ff == S_IDLE) && cmd_valid && pend_free;
   assign top_h     = tops_ff[cmd.segment];
   assign top0      = tops_ff[SEG_LOCAL];
   assign base_h    = seg_base(cmd.segment);
   assign value_ext = EXT_BITS'(cmd.value);
   assign alu_a     = ram_rdata;
   assign alu_b     = cmd_ff.unary ? ram_rdata : b_ff;
   assign r_ext     = EXT_BITS'(alu_r);
   assign rd_ext    = EXT_BITS'(ram_rdata);

   always_comb begin
      case (cmd_ff.op)
         OP_ADD:  alu_r = alu_a + alu_b;
         OP_SUB:  alu_r = alu_a - alu_b;
         OP_NEG:  alu_r = '0 - alu_b;
         OP_EQ:   alu_r = (alu_a == alu_b) ? '1 : '0;
         OP_GT:   alu_r = ($signed(alu_a) > $signed(alu_b)) ? '1 : '0;
         OP_LT:   alu_r = ($signed(alu_a) < $signed(alu_b)) ? '1 : '0;
         OP_AND:  alu_r = alu_a & alu_b;
         OP_OR:   alu_r = alu_a | alu_b;
         default: alu_r = ~alu_b;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      tops_in        = tops_ff;
      cmd_in         = cmd_ff;
      b_in           = b_ff;
      pend_in        = pend_ff && !move;
      pend_data_in   = pend_data_ff;
      pend_status_in = pend_status_ff;
      out_valid_in   = out_valid_ff;
      out_data_in    = out_data_ff;
      out_status_in  = out_status_ff;
      ram_addr       = '0;
      ram_we         = 1'b0;
      ram_wdata      = value_ext[WORD_BITS-1:0];

      // drain the pending word into the output register
      if (move) begin
         out_valid_in  = 1'b1;
         out_data_in   = pend_data_ff;
         out_status_in = pend_status_ff;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_take) begin
               cmd_in       = cmd;
               pend_data_in = '0;
               unique case (cmd.kind)
                  K_PUSH: begin
                     pend_in = 1'b1;
                     if (top_h >= seg_cap(cmd.segment)) begin
                        pend_status_in = ST_OVERFLOW;
                     end else begin
                        pend_status_in        = ST_OK;
                        ram_we                = 1'b1;
                        ram_addr              = base_h + ADDR_BITS'(top_h);
                        tops_in[cmd.segment]  = top_h + TOP_BITS'(1);
                     end
                  end
                  K_POP, K_PEEK: begin
                     if (top_h == '0) begin
                        pend_in        = 1'b1;
                        pend_status_in = ST_EMPTY;
                     end else begin
                        ram_addr = base_h + ADDR_BITS'(top_h - TOP_BITS'(1));
                        state_in = S_CALC;
                     end
                  end
                  K_ALU: begin
                     if ((top0 == '0) || (!cmd.unary && (top0 == TOP_BITS'(1)))) begin
                        pend_in        = 1'b1;
                        pend_status_in = ST_FEW;
                     end else begin
                        ram_addr = ADDR_BITS'(top0 - TOP_BITS'(1));
                        state_in = cmd.unary ? S_CALC : S_READ_A;
                     end
                  end
                  K_NOP: begin
                     pend_in        = 1'b1;
                     pend_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_READ_A: begin
            b_in     = ram_rdata;
            ram_addr = ADDR_BITS'(top0 - TOP_BITS'(2));
            state_in = S_CALC;
         end
         S_CALC: begin
            pend_in        = 1'b1;
            pend_status_in = ST_OK;
            state_in       = S_IDLE;
            if (cmd_ff.kind == K_ALU) begin
               ram_we       = 1'b1;
               ram_wdata    = alu_r;
               pend_data_in = r_ext[OUT_BITS-1:0];
               if (cmd_ff.unary) begin
                  ram_addr = ADDR_BITS'(top0 - TOP_BITS'(1));
               end else begin
                  ram_addr           = ADDR_BITS'(top0 - TOP_BITS'(2));
                  tops_in[SEG_LOCAL] = top0 - TOP_BITS'(1);
               end
            end else begin
               pend_data_in = rd_ext[OUT_BITS-1:0];
               if (cmd_ff.kind == K_POP) begin
                  tops_in[cmd_ff.segment] = tops_ff[cmd_ff.segment] - TOP_BITS'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      b_ff           <= b_in;
      pend_data_ff   <= pend_data_in;
      pend_status_ff <= pend_status_in;
      out_data_ff    <= out_data_in;
      out_status_ff  <= out_status_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         tops_ff      <= '{default: '0};
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tops_ff      <= tops_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign empty  = !out_valid_ff;
   assign data   = out_data_ff;
   assign status = out_status_ff;

endmodule

// ----- rtl/core/segmented_stack_alu.sv -----
// channel   ports                                   handshake
// request   operation, segment, value               push / full
// response  data, status                            empty / pop
//
// Push, nop and every error end in the back end's S_IDLE state; pop, peek, neg
// and not add S_CALC, binary ops S_READ_A and S_CALC: one single-port RAM access per cycle.
// Synchronous reset empties all seven stacks, the request queue and the response.
// Stack storage is not cleared; only entries below a stack's count are read.
// A 2-word queue parts front and back; a pending word and an output register
// let the back end finish while the consumer stalls.
module segmented_stack_alu #(
   parameter int DEPTH         = 256,
   parameter int TEMP_DEPTH    = 8,
   parameter int POINTER_DEPTH = 2,
   parameter int WORD_BITS     = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [3:0]         req_operation,
   input  logic [2:0]         req_segment,
   input  logic signed [15:0] req_value,
   output logic               empty,
   input  logic               pop,
   output logic signed [15:0] rsp_data,
   output logic [1:0]         rsp_status
);

   import ssalu_pkg::*;

   localparam int RAM_WORDS = NUM_MAIN_SEGS * DEPTH + TEMP_DEPTH + POINTER_DEPTH;
   localparam int ADDR_BITS = $clog2(RAM_WORDS);

   logic                 cmd_valid;
   logic                 cmd_take;
   cmd_type              cmd;
   logic [ADDR_BITS-1:0] ram_addr;
   logic                 ram_we;
   logic [WORD_BITS-1:0] ram_wdata;
   logic [WORD_BITS-1:0] ram_rdata;

   ssalu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .operation (req_operation),
      .segment   (req_segment),
      .value     (req_value),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   ssalu_back #(
      .DEPTH         (DEPTH),
      .TEMP_DEPTH    (TEMP_DEPTH),
      .POINTER_DEPTH (POINTER_DEPTH),
      .WORD_BITS     (WORD_BITS),
      .RAM_WORDS     (RAM_WORDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .ram_addr  (ram_addr),
      .ram_we    (ram_we),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata),
      .empty     (empty),
      .pop       (pop),
      .data      (rsp_data),
      .status    (rsp_status)
   );

   ssalu_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (RAM_WORDS)
   ) u_ram (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   a_take_needs_word: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid)
      else $error("back end took a word from an empty queue");

   a_accept_queues: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> cmd_valid)
      else $error("accepted request word missing from queue");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ({1'b0, ram_addr} < (ADDR_BITS + 1)'(RAM_WORDS)))
      else $error("stack write outside storage");

endmodule

// ----- sim/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ssalu_pkg::*;

   localparam int DEPTH         = 256;
   localparam int TEMP_DEPTH    = 8;
   localparam int POINTER_DEPTH = 2;
   localparam int STORE_WORDS   = NUM_MAIN_SEGS * DEPTH + TEMP_DEPTH + POINTER_DEPTH;
   localparam int STALL_LIMIT   = 4000;
   localparam int MIX_WORDS     = 600;

   localparam logic [2:0] SEG_NONE     = 3'd7;
   localparam logic [3:0] OP_NOP_FIRST = 4'd12;
   localparam logic [3:0] OP_NOP_LAST  = 4'd15;

   typedef struct packed {
      logic [15:0] data;
      logic [1:0]  status;
   } result_type;

   typedef struct packed {
      logic [3:0]  op;
      logic [2:0]  seg;
      logic [15:0] val;
      logic        typed;
      result_type  res;
   } script_row_type;

   localparam int NUM_ROWS = 30;

   script_row_type directed_rows [NUM_ROWS] = '{
      '{OP_POP,       SEG_LOCAL,    16'h0000, 1'b1, '{16'h0000, ST_EMPTY}},
      '{OP_PEEK,      SEG_POINTER,  16'h0000, 1'b1, '{16'h0000, ST_EMPTY}},
      '{OP_ADD,       SEG_LOCAL,    16'h0000, 1'b1, '{16'h0000, ST_FEW}},
      '{OP_NOT,       SEG_THAT,     16'h0000, 1'b1, '{16'h0000, ST_FEW}},
      '{OP_PUSH,      SEG_NONE,     16'h1234, 1'b1, '{16'h0000, ST_OVERFLOW}},
      '{OP_PEEK,      SEG_NONE,     16'h0000, 1'b1, '{16'h0000, ST_EMPTY}},
      '{OP_NOP_FIRST, SEG_LOCAL,    16'hFFFF, 1'b1, '{16'h0000, ST_OK}},
      '{OP_NOP_LAST,  SEG_NONE,     16'h8000, 1'b1, '{16'h0000, ST_OK}},
      '{OP_PUSH,      SEG_LOCAL,    16'h7FFF, 1'b1, '{16'h0000, ST_OK}},
      '{OP_EQ,        SEG_LOCAL,    16'h0000, 1'b1, '{16'h0000, ST_FEW}},
      '{OP_PUSH,      SEG_LOCAL,    16'h8000, 1'b1, '{16'h0000, ST_OK}},
      '{OP_GT,        SEG_LOCAL,    16'h0000, 1'b0, '{16'h0000, ST_OK}},
      '{OP_PUSH,      SEG_LOCAL,    16'h8000, 1'b1, '{16'h0000, ST_OK}},
      '{OP_LT,        SEG_LOCAL,    16'h0000, 1'b0, '{16'h0000, ST_OK}},
      '{OP_PUSH,      SEG_LOCAL,    16'h5555, 1'b1, '{16'h0000, ST_OK}},
      '{OP_AND,       SEG_LOCAL,    16'h0000, 1'b0, '{16'h0000, ST_OK}},
      '{OP_PUSH,      SEG_LOCAL,    16'hAAAA, 1'b1, '{16'h0000, ST_OK}},
      '{OP_OR,        SEG_LOCAL,    16'h0000, 1'b0, '{16'h0000, ST_OK}},
      '{OP_NOT,       SEG_LOCAL,    16'h0000, 1'b0, '{16'h0000, ST_OK}},
      '{OP_NEG,       SEG_LOCAL,    16'h0000, 1'b0, '{16'h0000, ST_OK}},
      '{OP_PUSH,      SEG_LOCAL,    16'h7FFF, 1'b1, '{16'h0000, ST_OK}},
      '{OP_PUSH,      SEG_LOCAL,    16'h0001, 1'b1, '{16'h0000, ST_OK}},
      '{OP_ADD,       SEG_LOCAL,    16'h0000, 1'b0, '{16'h0000, ST_OK}},
      '{OP_SUB,       SEG_LOCAL,    16'h0000, 1'b0, '{16'h0000, ST_OK}},
      '{OP_POP,       SEG_LOCAL,    16'h0000, 1'b0, '{16'h0000, ST_OK}},
      '{OP_PUSH,      SEG_POINTER,  16'h0000, 1'b1, '{16'h0000, ST_OK}},
      '{OP_PUSH,      SEG_POINTER,  16'hFFFF, 1'b1, '{16'h0000, ST_OK}},
      '{OP_PUSH,      SEG_POINTER,  16'h0001, 1'b1, '{16'h0000, ST_OVERFLOW}},
      '{OP_POP,       SEG_POINTER,  16'h0000, 1'b1, '{16'hFFFF, ST_OK}},
      '{OP_PEEK,      SEG_TEMP,     16'h0000, 1'b1, '{16'h0000, ST_EMPTY}}
   };

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               push          = 1'b0;
   logic               full;
   logic [3:0]         req_operation = '0;
   logic [2:0]         req_segment   = '0;
   logic signed [15:0] req_value     = '0;
   logic               empty;
   logic               pop           = 1'b0;
   logic signed [15:0] rsp_data;
   logic [1:0]         rsp_status;

   logic [15:0] stack_words [STORE_WORDS];
   int          stack_depth [8] = '{default: 0};
   result_type  awaited_results [$];
   result_type  oldest;
   bit          steady      = 1'b0;
   int          fail_count  = 0;
   int          idle_cycles = 0;

   segmented_stack_alu #(
      .DEPTH         (DEPTH),
      .TEMP_DEPTH    (TEMP_DEPTH),
      .POINTER_DEPTH (POINTER_DEPTH),
      .WORD_BITS     (16)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_operation (req_operation),
      .req_segment   (req_segment),
      .req_value     (req_value),
      .empty         (empty),
      .pop           (pop),
      .rsp_data      (rsp_data),
      .rsp_status    (rsp_status)
   );

   always #6 clock = ~clock;

   function automatic result_type stack_alu_step(input logic [3:0] op, input logic [2:0] seg,
                                                 input logic [15:0] val);
      result_type  res;
      int          cap;
      int          base;
      int          top;
      int          need;
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] r;
      res = '0;
      if (op <= OP_PEEK) begin
         case (seg)
            SEG_TEMP: begin
               cap  = TEMP_DEPTH;
               base = NUM_MAIN_SEGS * DEPTH;
            end
            SEG_POINTER: begin
               cap  = POINTER_DEPTH;
               base = NUM_MAIN_SEGS * DEPTH + TEMP_DEPTH;
            end
            SEG_NONE: begin
               cap  = 0;
               base = 0;
            end
            default: begin
               cap  = DEPTH;
               base = int'(seg) * DEPTH;
            end
         endcase
         top = stack_depth[seg];
         if (op == OP_PUSH) begin
            if (top >= cap) begin
               res.status = ST_OVERFLOW;
            end else begin
               stack_words[base + top] = val;
               stack_depth[seg] = top + 1;
            end
         end else if (top == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.data = stack_words[base + top - 1];
            if (op == OP_POP) stack_depth[seg] = top - 1;
         end
      end else if (op <= OP_NOT) begin
         top  = stack_depth[SEG_LOCAL];
         need = (op == OP_NEG || op == OP_NOT) ? 1 : 2;
         if (top < need) begin
            res.status = ST_FEW;
         end else begin
            b = stack_words[top - 1];
            a = (need == 2) ? stack_words[top - 2] : 16'h0000;
            case (op)
               OP_ADD:  r = a + b;
               OP_SUB:  r = a - b;
               OP_NEG:  r = 16'h0000 - b;
               OP_EQ:   r = (a == b) ? 16'hFFFF : 16'h0000;
               OP_GT:   r = ($signed(a) > $signed(b)) ? 16'hFFFF : 16'h0000;
               OP_LT:   r = ($signed(a) < $signed(b)) ? 16'hFFFF : 16'h0000;
               OP_AND:  r = a & b;
               OP_OR:   r = a | b;
               default: r = ~b;
            endcase
            top = top - need;
            stack_words[top] = r;
            stack_depth[SEG_LOCAL] = top + 1;
            res.data = r;
         end
      end
      return res;
   endfunction

   task automatic send_word(input logic [3:0] op, input logic [2:0] seg, input logic [15:0] val,
                            input logic typed, input result_type typed_res);
      int         gap;
      result_type res;
      gap = 0;
      if (!steady) while ($urandom_range(0, 99) < 38) gap++;
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push          <= 1'b1;
      req_operation <= op;
      req_segment   <= seg;
      req_value     <= val;
      @(posedge clock);
      while (full) @(posedge clock);
      res = stack_alu_step(op, seg, val);
      awaited_results.push_back(typed ? typed_res : res);
   endtask

   task automatic drain_results();
      push <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected word: data %0d status %0d", rsp_data, rsp_status);
               fail_count++;
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_data !== oldest.data) begin
                  $error("data expected %0d actual %0d", $signed(oldest.data), rsp_data);
                  fail_count++;
               end
               if (rsp_status !== oldest.status) begin
                  $error("status expected %0d actual %0d", oldest.status, rsp_status);
                  fail_count++;
               end
            end
         end
         pop <= steady || ($urandom_range(0, 99) >= 38);
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else begin
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int          pick;
      int          fill_seg;
      logic [3:0]  op;
      logic [2:0]  seg;
      logic [15:0] val;
      logic [15:0] last_val;
      last_val = 16'h0000;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         send_word(directed_rows[i].op, directed_rows[i].seg, directed_rows[i].val,
                   directed_rows[i].typed, directed_rows[i].res);
      end
      drain_results();

      // fill one main segment to overflow, then take part of it back
      fill_seg = $urandom_range(SEG_LOCAL, SEG_STATIC);
      while (stack_depth[fill_seg] < DEPTH) begin
         send_word(OP_PUSH, 3'(fill_seg), 16'($urandom_range(0, 65535)), 1'b0, '0);
      end
      send_word(OP_PUSH, 3'(fill_seg), 16'($urandom_range(0, 65535)), 1'b0, '0);
      repeat (12) send_word(OP_POP, 3'(fill_seg), 16'($urandom_range(0, 65535)), 1'b0, '0);
      drain_results();

      for (int i = 0; i < MIX_WORDS; i++) begin
         steady = (i >= 250 && i < 400);
         if (i == 450) drain_results();
         pick = $urandom_range(0, 99);
         seg  = ($urandom_range(0, 1) == 0) ? SEG_LOCAL : 3'($urandom_range(0, 7));
         val  = 16'($urandom_range(0, 65535));
         case ($urandom_range(0, 9))
            0: val = 16'h8000;
            1: val = 16'h7FFF;
            2: val = last_val;
            default: ;
         endcase
         if (stack_depth[SEG_LOCAL] < 2 && pick < 80) begin
            op  = OP_PUSH;
            seg = SEG_LOCAL;
         end else if (pick < 30) begin
            op = OP_PUSH;
         end else if (pick < 45) begin
            op = ($urandom_range(0, 1) == 0) ? OP_POP : OP_PEEK;
         end else if (pick < 94) begin
            op = 4'($urandom_range(OP_ADD, OP_NOT));
         end else begin
            op = 4'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
         end
         if (op == OP_PUSH) last_val = val;
         send_word(op, seg, val, 1'b0, '0);
      end
      steady = 1'b0;

      push <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
